FILE: rtl/phfi_pkg.sv
`timescale 1ns / 1ps
// phfi_pkg: shared types, sizes and the bucket hash for the plane key table.
// No dependencies; imported by every module of the block except phfi_ram.
package phfi_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int BUCKETS       = 256;
  localparam int BKT_W         = $clog2(BUCKETS);
  localparam int ENTRY_W       = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = QPTR_W + 1;

  localparam logic [31:0] HASH_K_HEIGHT  = 32'd73856093;
  localparam logic [31:0] HASH_K_TEXTURE = 32'd19349663;
  localparam logic [31:0] HASH_K_LIGHT   = 32'd83492791;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] plane_height;
    logic [15:0]        texture_number;
    logic [7:0]         light_level;
  } in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_index;
    logic               created;
    logic               table_full;
  } out_t;

  typedef struct packed {
    logic [31:0] height;
    logic [15:0] texture;
    logic [7:0]  light;
  } key_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } link_t;

  typedef struct packed {
    key_t  key;
    link_t link;
  } entry_t;

  typedef struct packed {
    logic             clear;
    key_t             key;
    logic [BKT_W-1:0] bucket;
  } work_t;

  // only the low bucket bits of each product survive the mask, so narrow
  // products are enough; bits [23:16] of the height are the low byte of its
  // arithmetically shifted whole part
  function automatic logic [BKT_W-1:0] bucket_of(key_t k);
    logic [BKT_W-1:0] ph;
    logic [BKT_W-1:0] pt;
    logic [BKT_W-1:0] pl;
    ph = BKT_W'(k.height[16 +: BKT_W]) * BKT_W'(HASH_K_HEIGHT);
    pt = BKT_W'(k.texture) * BKT_W'(HASH_K_TEXTURE);
    pl = BKT_W'(k.light) * BKT_W'(HASH_K_LIGHT);
    return ph ^ pt ^ pl;
  endfunction

endpackage

FILE: rtl/plane_hash_find_or_insert_core.sv
`timescale 1ns / 1ps
// A transaction passes from the front end through the queue to the back end; a
// clear is handled in the idle state, a lookup reads the bucket head, then walks one
// chain entry per cycle through the entry RAM's registered read and inserts when no
// entry matches. The back end takes its next item only once it is back in idle; a
// 2-deep queue keeps input open meanwhile. Reset (rst, synchronous): all buckets
// empty, entry count 0, sky texture 0; no clearing pass is needed, bucket valid bits are flip-flops.
module plane_hash_find_or_insert_core import phfi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_item
);

  logic  push;
  logic  push_ready;
  work_t push_item;
  logic  q_valid;
  logic  q_pop;
  work_t q_item;

  phfi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  phfi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .push_ready(push_ready),
    .pop       (q_pop),
    .pop_item  (q_item),
    .pop_valid (q_valid)
  );

  phfi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

FILE: rtl/phfi_ram.sv
`timescale 1ns / 1ps
// phfi_ram: generic single write, single read RAM with registered read data.
// No dependencies.
module phfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/phfi_front.sv
`timescale 1ns / 1ps
// phfi_front: accepts input transactions, folds sky planes and hashes the key.
// Depends on phfi_pkg; holds the sky texture register.
module phfi_front import phfi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_item,
  output logic        push,
  output work_t       push_item,
  input  logic        push_ready
);

  logic [15:0] sky_texture;
  key_t        key;

  always_ff @(posedge clk) begin
    if (rst) begin
      sky_texture <= '0;
    end else if (cfg_wr_en) begin
      sky_texture <= cfg_wr_data;
    end
  end

  always_comb begin
    key.height  = in_item.plane_height;
    key.texture = in_item.texture_number;
    key.light   = in_item.light_level;
    // all sky planes share one key
    if (in_item.texture_number == sky_texture) begin
      key.height = '0;
      key.light  = '0;
    end
  end

  assign in_ready         = push_ready;
  assign push             = in_valid && push_ready;
  assign push_item.clear  = in_item.mode;
  assign push_item.key    = key;
  assign push_item.bucket = bucket_of(key);

endmodule

FILE: rtl/phfi_queue.sv
`timescale 1ns / 1ps
// phfi_queue: short fifo of classified work between front and back.
// Depends on phfi_pkg for the work type and depth.
module phfi_queue import phfi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_item,
  output logic  push_ready,
  input  logic  pop,
  output work_t pop_item,
  output logic  pop_valid
);

  work_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/phfi_back.sv
`timescale 1ns / 1ps
// phfi_back: walks the bucket chain, inserts new keys, clears the table and holds the result.
// Depends on phfi_pkg and phfi_ram (bucket head and entry stores).
module phfi_back import phfi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  input  work_t q_item,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_item
);

  typedef enum logic [1:0] {S_IDLE, S_HEAD, S_WALK, S_INSERT} state_t;

  state_t             state;
  work_t              cur;
  logic [IDX_W-1:0]   walk_idx;
  link_t              head_link;
  logic [CNT_W-1:0]   entries_used;
  logic [BUCKETS-1:0] head_valid;

  logic               out_free;
  logic               out_load;
  logic               match;
  logic               full;
  logic               do_insert;
  logic [IDX_W-1:0]   head_rd_data;
  logic [IDX_W-1:0]   key_rd_addr;
  entry_t             key_rd_data;
  entry_t             key_wr_data;

  assign out_free  = !out_valid || out_ready;
  assign match     = key_rd_data.key == cur.key;
  assign full      = entries_used == CNT_W'(TABLE_ENTRIES);
  assign do_insert = (state == S_INSERT) && out_free && !full;
  assign q_pop     = (state == S_IDLE) && q_valid && (!q_item.clear || out_free);

  // a result is loaded only when the output register is free
  assign out_load  = (q_pop && q_item.clear) ||
                     ((state == S_WALK) && match && out_free) ||
                     ((state == S_INSERT) && out_free);

  assign key_wr_data.key  = cur.key;
  assign key_wr_data.link = head_link;

  // entry read address is the index whose data arrives next cycle
  always_comb begin
    key_rd_addr = walk_idx;
    case (state)
      S_HEAD: key_rd_addr = head_rd_data;
      S_WALK: begin
        if (!match && key_rd_data.link.vld) begin
          key_rd_addr = key_rd_data.link.idx;
        end
      end
      default: key_rd_addr = walk_idx;
    endcase
  end

  phfi_ram #(
    .WIDTH(IDX_W),
    .DEPTH(BUCKETS)
  ) u_head_ram (
    .clk    (clk),
    .wr_en  (do_insert),
    .wr_addr(cur.bucket),
    .wr_data(entries_used[IDX_W-1:0]),
    .rd_addr(q_item.bucket),
    .rd_data(head_rd_data)
  );

  phfi_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (do_insert),
    .wr_addr(entries_used[IDX_W-1:0]),
    .wr_data(key_wr_data),
    .rd_addr(key_rd_addr),
    .rd_data(key_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entries_used <= '0;
      head_valid   <= '0;
      out_valid    <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur <= q_item;
            if (q_item.clear) begin
              head_valid   <= '0;
              entries_used <= '0;
              out_item     <= '{entry_index: '0, created: 1'b0, table_full: 1'b0};
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          head_link.vld <= head_valid[cur.bucket];
          head_link.idx <= head_rd_data;
          walk_idx      <= head_rd_data;
          state         <= head_valid[cur.bucket] ? S_WALK : S_INSERT;
        end
        S_WALK: begin
          if (match) begin
            if (out_free) begin
              out_item  <= '{entry_index: ENTRY_W'(walk_idx), created: 1'b0,
                             table_full: 1'b0};
              state     <= S_IDLE;
            end
          end else if (key_rd_data.link.vld) begin
            walk_idx <= key_rd_data.link.idx;
          end else begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (out_free) begin
            state <= S_IDLE;
            if (full) begin
              out_item <= '{entry_index: '0, created: 1'b0, table_full: 1'b1};
            end else begin
              out_item <= '{entry_index: ENTRY_W'(entries_used[IDX_W-1:0]),
                            created: 1'b1, table_full: 1'b0};
              entries_used           <= entries_used + 1'b1;
              head_valid[cur.bucket] <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
